>>> rtl/stl_pkg.sv
// shared types and constants of the source text lexer
package stl_pkg;

   // result kinds
   typedef enum logic [5:0] {
      K_END    = 6'd0,
      K_COLON  = 6'd1,
      K_SEMI   = 6'd2,
      K_COMMA  = 6'd3,
      K_DOT    = 6'd4,
      K_LPAREN = 6'd5,
      K_RPAREN = 6'd6,
      K_LBRACK = 6'd7,
      K_RBRACK = 6'd8,
      K_LBRACE = 6'd9,
      K_RBRACE = 6'd10,
      K_ADD    = 6'd11,
      K_SUB    = 6'd12,
      K_MUL    = 6'd13,
      K_DIV    = 6'd14,
      K_MOD    = 6'd15,
      K_AND    = 6'd16,
      K_OR     = 6'd17,
      K_XOR    = 6'd18,
      K_TILDE  = 6'd19,
      K_COND   = 6'd20,
      K_AT     = 6'd21,
      K_ATAT   = 6'd22,
      K_RET    = 6'd23,
      K_CEQ    = 6'd24,
      K_NOT    = 6'd25,
      K_CNE    = 6'd26,
      K_CLT    = 6'd27,
      K_CLE    = 6'd28,
      K_BLS    = 6'd29,
      K_CGT    = 6'd30,
      K_CGE    = 6'd31,
      K_BRS    = 6'd32,
      K_INT    = 6'd33,
      K_DBL    = 6'd34,
      K_IDENT  = 6'd35,
      K_STR    = 6'd36,
      K_VAL    = 6'd37,
      K_ERR    = 6'd38
   } kind_type;

   localparam int KIND_W = 6;
   localparam int BYTE_W = 8;

   // default depth of the result queue
   localparam int RSP_DEPTH_DEF = 4;

   // one result item
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] value_byte;
      logic              last;
   } rsp_type;

   // the results of one step, in order
   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    res0;
      rsp_type    res1;
   } step_type;

endpackage

>>> rtl/stl_step.sv
// lexer state register and the per-byte token logic
module stl_step (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic [stl_pkg::BYTE_W-1:0] char_in,
   input  logic                       end_of_input,
   output stl_pkg::step_type          step
);
   import stl_pkg::*;

   typedef enum logic [3:0] {
      ST_BEGIN   = 4'd0,
      ST_AT      = 4'd1,
      ST_NOT     = 4'd2,
      ST_LT      = 4'd3,
      ST_GT      = 4'd4,
      ST_EQ      = 4'd5,
      ST_COMMENT = 4'd6,
      ST_INT     = 4'd7,
      ST_DBL     = 4'd8,
      ST_IDENT   = 4'd9,
      ST_STR     = 4'd10,
      ST_ESC     = 4'd11
   } state_type;

   // character codes
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_NOT    = 8'h21;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_MOD    = 8'h25;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UZ     = 8'h5A;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LB     = 8'h62;
   localparam logic [7:0] CH_LF     = 8'h66;
   localparam logic [7:0] CH_LN     = 8'h6E;
   localparam logic [7:0] CH_LR     = 8'h72;
   localparam logic [7:0] CH_LT_T   = 8'h74;
   localparam logic [7:0] CH_LZ     = 8'h7A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   state_type state_ff, state_in;

   logic is_digit, is_alpha, is_ident;

   // start-state decode of the current byte
   logic            sb_v;
   logic [5:0]      sb_k;
   logic [7:0]      sb_b;
   state_type       sb_st;

   // escape translation
   logic            esc_ok;
   logic [7:0]      esc_b;

   // up to two results
   logic            v0, v1;
   logic [5:0]      k0, k1;
   logic [7:0]      b0, b1;

   assign is_digit = (char_in >= CH_0) && (char_in <= CH_9);
   assign is_alpha = ((char_in >= CH_LA) && (char_in <= CH_LZ)) ||
                     ((char_in >= CH_UA) && (char_in <= CH_UZ));
   assign is_ident = (char_in == CH_UNDER) || is_alpha || is_digit;

   // byte seen in the start state
   always_comb begin
      sb_v  = 1'b0;
      sb_k  = K_END;
      sb_b  = '0;
      sb_st = ST_BEGIN;
      case (char_in)
         CH_DOLLAR: begin sb_v = 1'b1; sb_k = K_END;    end
         CH_HASH:   sb_st = ST_COMMENT;
         CH_AT:     sb_st = ST_AT;
         CH_QUOTE:  sb_st = ST_STR;
         CH_EQ:     sb_st = ST_EQ;
         CH_NOT:    sb_st = ST_NOT;
         CH_LT:     sb_st = ST_LT;
         CH_GT:     sb_st = ST_GT;
         CH_COLON:  begin sb_v = 1'b1; sb_k = K_COLON;  end
         CH_SEMI:   begin sb_v = 1'b1; sb_k = K_SEMI;   end
         CH_COMMA:  begin sb_v = 1'b1; sb_k = K_COMMA;  end
         CH_DOT:    begin sb_v = 1'b1; sb_k = K_DOT;    end
         CH_LPAREN: begin sb_v = 1'b1; sb_k = K_LPAREN; end
         CH_RPAREN: begin sb_v = 1'b1; sb_k = K_RPAREN; end
         CH_LBRACK: begin sb_v = 1'b1; sb_k = K_LBRACK; end
         CH_RBRACK: begin sb_v = 1'b1; sb_k = K_RBRACK; end
         CH_LBRACE: begin sb_v = 1'b1; sb_k = K_LBRACE; end
         CH_RBRACE: begin sb_v = 1'b1; sb_k = K_RBRACE; end
         CH_PLUS:   begin sb_v = 1'b1; sb_k = K_ADD;    end
         CH_MINUS:  begin sb_v = 1'b1; sb_k = K_SUB;    end
         CH_STAR:   begin sb_v = 1'b1; sb_k = K_MUL;    end
         CH_SLASH:  begin sb_v = 1'b1; sb_k = K_DIV;    end
         CH_MOD:    begin sb_v = 1'b1; sb_k = K_MOD;    end
         CH_AMP:    begin sb_v = 1'b1; sb_k = K_AND;    end
         CH_PIPE:   begin sb_v = 1'b1; sb_k = K_OR;     end
         CH_CARET:  begin sb_v = 1'b1; sb_k = K_XOR;    end
         CH_TILDE:  begin sb_v = 1'b1; sb_k = K_TILDE;  end
         CH_QUEST:  begin sb_v = 1'b1; sb_k = K_COND;   end
         default: begin
            if (is_digit) begin
               sb_v  = 1'b1;
               sb_k  = K_VAL;
               sb_b  = char_in;
               sb_st = ST_INT;
            end else if (is_ident) begin
               sb_v  = 1'b1;
               sb_k  = K_VAL;
               sb_b  = char_in;
               sb_st = ST_IDENT;
            end
         end
      endcase
   end

   // escape sequences in strings
   always_comb begin
      esc_ok = 1'b1;
      esc_b  = '0;
      case (char_in)
         CH_LN:     esc_b = 8'h0A;
         CH_BSLASH: esc_b = CH_BSLASH;
         CH_QUOTE:  esc_b = CH_QUOTE;
         CH_LA:     esc_b = 8'h07;
         CH_LB:     esc_b = 8'h08;
         CH_0:      esc_b = 8'h00;
         CH_LT_T:   esc_b = 8'h09;
         CH_LR:     esc_b = 8'h0D;
         CH_LF:     esc_b = 8'h0C;
         default:   esc_ok = 1'b0;
      endcase
   end

   // main transition, pending token first and then the byte itself
   always_comb begin
      v0 = 1'b0; k0 = K_END; b0 = '0;
      v1 = 1'b0; k1 = K_END; b1 = '0;
      state_in = state_ff;
      if (end_of_input) begin
         v0 = 1'b1;
         state_in = ST_BEGIN;
         case (state_ff)
            ST_AT:    k0 = K_AT;
            ST_EQ:    k0 = K_CEQ;
            ST_NOT:   k0 = K_NOT;
            ST_LT:    k0 = K_CLT;
            ST_GT:    k0 = K_CGT;
            ST_INT:   k0 = K_INT;
            ST_DBL:   k0 = K_DBL;
            ST_IDENT: k0 = K_IDENT;
            default:  v0 = 1'b0;
         endcase
         if (v0) begin
            v1 = 1'b1; k1 = K_END;
         end else begin
            v0 = 1'b1; k0 = K_END;
         end
      end else begin
         case (state_ff)
            ST_AT, ST_EQ, ST_NOT, ST_LT, ST_GT: begin
               v0 = 1'b1;
               state_in = ST_BEGIN;
               if (state_ff == ST_AT && char_in == CH_AT) begin
                  k0 = K_ATAT;
               end else if (state_ff == ST_EQ && char_in == CH_GT) begin
                  k0 = K_RET;
               end else if (state_ff == ST_NOT && char_in == CH_EQ) begin
                  k0 = K_CNE;
               end else if (state_ff == ST_LT && char_in == CH_EQ) begin
                  k0 = K_CLE;
               end else if (state_ff == ST_LT && char_in == CH_LT) begin
                  k0 = K_BLS;
               end else if (state_ff == ST_GT && char_in == CH_EQ) begin
                  k0 = K_CGE;
               end else if (state_ff == ST_GT && char_in == CH_GT) begin
                  k0 = K_BRS;
               end else begin
                  case (state_ff)
                     ST_AT:   k0 = K_AT;
                     ST_EQ:   k0 = K_CEQ;
                     ST_NOT:  k0 = K_NOT;
                     ST_LT:   k0 = K_CLT;
                     default: k0 = K_CGT;
                  endcase
                  v1 = sb_v; k1 = sb_k; b1 = sb_b;
                  state_in = sb_st;
               end
            end
            ST_COMMENT: begin
               if (char_in == CH_NL) state_in = ST_BEGIN;
            end
            ST_INT, ST_DBL: begin
               v0 = 1'b1;
               if (state_ff == ST_INT && char_in == CH_DOT) begin
                  k0 = K_VAL; b0 = char_in;
                  state_in = ST_DBL;
               end else if (is_digit) begin
                  k0 = K_VAL; b0 = char_in;
               end else begin
                  k0 = (state_ff == ST_INT) ? K_INT : K_DBL;
                  v1 = sb_v; k1 = sb_k; b1 = sb_b;
                  state_in = sb_st;
               end
            end
            ST_IDENT: begin
               v0 = 1'b1;
               if (is_ident) begin
                  k0 = K_VAL; b0 = char_in;
               end else begin
                  k0 = K_IDENT;
                  v1 = sb_v; k1 = sb_k; b1 = sb_b;
                  state_in = sb_st;
               end
            end
            ST_STR: begin
               if (char_in == CH_NL) begin
                  v0 = 1'b1; k0 = K_ERR;
                  state_in = ST_BEGIN;
               end else if (char_in == CH_BSLASH) begin
                  state_in = ST_ESC;
               end else if (char_in == CH_QUOTE) begin
                  v0 = 1'b1; k0 = K_STR;
                  state_in = ST_BEGIN;
               end else begin
                  v0 = 1'b1; k0 = K_VAL; b0 = char_in;
               end
            end
            ST_ESC: begin
               v0 = 1'b1;
               if (char_in == CH_NL) begin
                  k0 = K_ERR;
                  state_in = ST_BEGIN;
               end else if (esc_ok) begin
                  k0 = K_VAL; b0 = esc_b;
                  state_in = ST_STR;
               end else begin
                  k0 = K_VAL; b0 = CH_BSLASH;
                  v1 = 1'b1; k1 = K_VAL; b1 = char_in;
                  state_in = ST_STR;
               end
            end
            default: begin
               v0 = sb_v; k0 = sb_k; b0 = sb_b;
               state_in = sb_st;
            end
         endcase
      end
   end

   // pack results in order, last flag on the final one
   always_comb begin
      step.cnt             = {1'b0, v0} + {1'b0, v1};
      step.res0.kind       = k0;
      step.res0.value_byte = b0;
      step.res0.last       = ~v1;
      step.res1.kind       = k1;
      step.res1.value_byte = b1;
      step.res1.last       = 1'b1;
   end

   // lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BEGIN;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/stl_rsp_fifo.sv
// result queue, up to two writes and one read per cycle
module stl_rsp_fifo #(
   parameter int DEPTH = stl_pkg::RSP_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stl_pkg::step_type step,
   output logic              room,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output stl_pkg::rsp_type  head
);
   import stl_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   rsp_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_nxt;
   logic [CNT_W-1:0] count_ff, count_in, add_cnt;
   logic             pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign room       = (count_ff <= CNT_W'(DEPTH - 2));
   assign add_cnt    = push ? CNT_W'(step.cnt) : '0;

   // pointer and count updates with wrap
   always_comb begin
      wr_nxt    = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff;
      if (add_cnt == CNT_W'(1)) begin
         wr_ptr_in = wr_nxt;
      end else if (add_cnt == CNT_W'(2)) begin
         wr_ptr_in = (wr_nxt == LAST_PTR) ? '0 : wr_nxt + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + add_cnt - CNT_W'(pop);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (add_cnt != '0) begin
         mem_ff[wr_ptr_ff] <= step.res0;
      end
      if (add_cnt == CNT_W'(2)) begin
         mem_ff[wr_nxt] <= step.res1;
      end
   end

endmodule

>>> rtl/source_text_lexer_top.sv
// Byte-serial source text lexer, top level.
// The request channel (req_) carries one source byte per request in
// req_tdata; req_tlast set marks end of input, and the byte is then ignored.
// Each request yields zero, one or two results on the rsp_ channel: a token
// kind, or a value byte (kind 37) of a number, identifier or string, or a
// syntax error (kind 38). rsp_tlast marks the last result of a request.
// A request is held in an input register and decoded against the lexer
// state once the result queue has room for two results; its results are
// written into that small result queue, which drives rsp_.
// Throughput is one request per cycle while the receiver takes results and
// the queue has room; a request that yields two results writes both into
// the queue at once. req_tready falls only when the queue lacks room for two
// results, so a stalled receiver holds all results and loses none.
// Reset (synchronous, active high) empties the queue and the input register
// and puts the lexer into its start state.
module source_text_lexer_top #(
   parameter int RSP_DEPTH = stl_pkg::RSP_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] kind, [13:6] value_byte, [15:14] zero
   output logic        rsp_tlast    // last
);
   import stl_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_char_ff;
   logic              in_eoi_ff;
   logic              room, fire, take;
   step_type          step;
   rsp_type           head;

   assign fire       = in_valid_ff && room;
   assign req_tready = ~in_valid_ff || room;
   assign take       = req_tvalid && req_tready;
   assign in_valid_in = take | (in_valid_ff & ~fire);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_char_ff <= req_tdata;
         in_eoi_ff  <= req_tlast;
      end
   end

   // token logic and lexer state
   stl_step u_step (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .char_in      (in_char_ff),
      .end_of_input (in_eoi_ff),
      .step         (step)
   );

   // result queue
   stl_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (fire),
      .step       (step),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = {2'b00, head.value_byte, head.kind};
   assign rsp_tlast = head.last;

endmodule
